/* hw/rtl/faa_pkg.sv */
// Shared types and constants for the field accumulate-and-average block.
// Used by the controller, datapath, top level and checker files.
package faa_pkg;

    localparam int ACC_W     = 48;
    localparam int SAMPLE_W  = 32;
    localparam int FL_W      = 11;
    localparam int POS_W     = 10;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int MAX_PASSES_DEF   = 65536;

    localparam logic [FL_W-1:0] FL_RESET = 11'd1024;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PREP,
        S_DIV,
        S_FIX,
        S_WB
    } t_state;

    typedef struct packed {
        logic accept;
        logic sum_load;
        logic div_prep;
        logic div_step;
        logic div_fix;
        logic write_back;
    } t_cmd;

    typedef struct packed {
        logic avg;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/faa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the accumulator slots; no package dependency.
module faa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/faa_ctrl.sv */
// Controller FSM: steps read, add, divide if averaging and write-back per item.
// Depends on faa_pkg for the state, command and status types.
module faa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output faa_pkg::t_cmd o_cmd,
    input  faa_pkg::t_stat i_stat
);

    faa_pkg::t_state r_state;
    faa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= faa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            faa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = faa_pkg::S_READ;
                end
            end
            faa_pkg::S_READ: begin
                o_cmd.sum_load = 1'b1;
                n_state        = i_stat.avg ? faa_pkg::S_PREP : faa_pkg::S_WB;
            end
            faa_pkg::S_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_state        = faa_pkg::S_DIV;
            end
            faa_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = faa_pkg::S_FIX;
                end
            end
            faa_pkg::S_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = faa_pkg::S_WB;
            end
            faa_pkg::S_WB: begin
                if (i_stat.out_free) begin
                    o_cmd.write_back = 1'b1;
                    n_state          = faa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = faa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/faa_dp.sv */
// Datapath: counters, accumulator RAM, saturating add, restoring divider and
// output register. Depends on faa_pkg and faa_ram.
module faa_dp #(
    parameter int MAX_ELEMENTS = faa_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_PASSES   = faa_pkg::MAX_PASSES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [faa_pkg::FL_W-1:0]        i_cfg_wr_data,
    input  logic [faa_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [0:0]                      i_s_tuser,
    input  faa_pkg::t_cmd                   i_cmd,
    output faa_pkg::t_stat                  o_stat,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [faa_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [0:0]                      o_m_tuser,
    output logic                            o_m_tlast
);

    localparam int CW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int PCW = $clog2(MAX_PASSES + 1);
    localparam int LW  = (CW + 1 > faa_pkg::FL_W) ? CW + 1 : faa_pkg::FL_W;
    localparam int AW  = faa_pkg::ACC_W;
    localparam int SW  = faa_pkg::SAMPLE_W;
    localparam int PW  = faa_pkg::POS_W;

    logic [faa_pkg::FL_W-1:0] r_field_length;
    logic [CW-1:0]            r_elem;
    logic [PCW-1:0]           r_pass;
    logic                     r_avg;
    logic [SW-1:0]            r_sample;
    logic [AW-1:0]            r_slot;
    logic [AW-1:0]            r_quo;
    logic [PCW-1:0]           r_rem;
    logic [faa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                     r_neg;
    logic                     r_m_tvalid;
    logic [AW-1:0]            r_m_result;
    logic [PW-1:0]            r_m_pos;
    logic                     r_m_avg;
    logic                     r_m_last;

    logic [AW-1:0] w_rd_data;
    logic [AW:0]   w_sum;
    logic [AW-1:0] w_sat;
    logic [AW-1:0] w_sample_ext;
    logic [AW-1:0] w_new;
    logic [PCW:0]  w_trial;
    logic [PCW:0]  w_diff;
    logic [PCW-1:0] w_div;
    logic          w_ge;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_elem_inc;
    logic          w_last;
    logic [CW+PW-1:0] w_pos_ext;

    faa_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write_back),
        .i_wr_addr (r_elem),
        .i_wr_data (r_slot),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (r_elem),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_sample_ext = {{(AW - SW){r_sample[SW-1]}}, r_sample};
        w_sum        = {w_rd_data[AW-1], w_rd_data} + {w_sample_ext[AW-1], w_sample_ext};
        if (w_sum[AW] != w_sum[AW-1]) begin
            w_sat = w_sum[AW] ? faa_pkg::ACC_MIN : faa_pkg::ACC_MAX;
        end else begin
            w_sat = w_sum[AW-1:0];
        end
        w_new = (r_pass <= PCW'(1)) ? w_sample_ext : w_sat;

        w_div   = (r_pass == '0) ? PCW'(1) : r_pass;
        w_trial = {r_rem, r_quo[AW-1]};
        w_diff  = w_trial - {1'b0, w_div};
        w_ge    = (w_trial >= {1'b0, w_div});

        if (r_field_length == '0) begin
            w_len = LW'(1);
        end else if (LW'(r_field_length) > LW'(MAX_ELEMENTS)) begin
            w_len = LW'(MAX_ELEMENTS);
        end else begin
            w_len = LW'(r_field_length);
        end
        w_elem_inc = LW'(r_elem) + LW'(1);
        w_last     = (w_elem_inc >= w_len);
        w_pos_ext  = {{PW{1'b0}}, r_elem};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_length <= faa_pkg::FL_RESET;
            r_elem         <= '0;
            r_pass         <= '0;
            r_avg          <= 1'b0;
            r_cnt          <= '0;
            r_m_tvalid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_field_length <= i_cfg_wr_data;
            end
            if (i_cmd.accept && (r_elem == '0)) begin
                r_avg <= i_s_tuser[0];
                if (r_pass < PCW'(MAX_PASSES)) begin
                    r_pass <= r_pass + PCW'(1);
                end
            end
            if (i_cmd.div_prep) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + faa_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.write_back) begin
                r_m_tvalid <= 1'b1;
                if (w_last) begin
                    r_elem <= '0;
                    if (r_avg) begin
                        r_pass <= '0;
                    end
                end else begin
                    r_elem <= r_elem + CW'(1);
                end
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_s_tdata[SW-1:0];
        end
        if (i_cmd.sum_load) begin
            r_slot <= w_new;
        end else if (i_cmd.div_fix) begin
            r_slot <= r_neg ? (AW'(0) - r_quo) : r_quo;
        end
        if (i_cmd.div_prep) begin
            r_neg <= r_slot[AW-1];
            r_quo <= r_slot[AW-1] ? (AW'(0) - r_slot) : r_slot;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[AW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PCW-1:0] : w_trial[PCW-1:0];
        end
        if (i_cmd.write_back) begin
            r_m_result <= r_slot;
            r_m_pos    <= w_pos_ext[PW-1:0];
            r_m_avg    <= r_avg;
            r_m_last   <= w_last;
        end
    end

    assign o_stat.avg      = r_avg;
    assign o_stat.div_done = (r_cnt == faa_pkg::DIV_CNT_W'(AW - 1));
    assign o_stat.out_free = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(faa_pkg::M_TDATA_W - AW - PW){1'b0}}, r_m_pos, r_m_result};
    assign o_m_tuser  = r_m_avg;
    assign o_m_tlast  = r_m_last;

endmodule

/* hw/rtl/field_accumulate_and_average.sv */
// Field accumulate-and-average block: one transfer in per field element, one transfer
// out per element. An ordinary pass handles each element by RAM read, saturating
// add and write-back; an averaging pass also runs the restoring divider, which
// produces one of the 48 quotient bits per cycle. The next element is taken while
// a finished result still waits in the output register. The accumulator RAM needs
// no clearing after reset; the user must write field_length only between transfers,
// which the block itself does not enforce. Depends on faa_pkg, faa_ctrl and faa_dp.
module field_accumulate_and_average #(
    parameter int MAX_ELEMENTS = faa_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_PASSES   = faa_pkg::MAX_PASSES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [faa_pkg::FL_W-1:0]      i_cfg_wr_data,  // field_length
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [faa_pkg::S_TDATA_W-1:0] i_s_tdata,      // [31:0] sample_value
    input  logic [0:0]                    i_s_tuser,      // [0] average_now
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [faa_pkg::M_TDATA_W-1:0] o_m_tdata,      // [47:0] result, [57:48] position
    output logic [0:0]                    o_m_tuser,      // [0] averaged
    output logic                          o_m_tlast       // last_element
);

    faa_pkg::t_cmd  w_cmd;
    faa_pkg::t_stat w_stat;

    faa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    faa_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_PASSES   (MAX_PASSES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

/* hw/rtl/faa_checker.sv */
// Port-level checker for the field accumulate-and-average top level, with its bind.
// Depends on faa_pkg for port widths.
module faa_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr_en,
    input logic [faa_pkg::FL_W-1:0]      i_cfg_wr_data,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [faa_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic [0:0]                    i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [faa_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]                    o_m_tuser,
    input logic                          o_m_tlast
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid not cleared by reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled output transfer changed.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Input taken again right after a transfer.");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("Result appeared one cycle after its input transfer.");

endmodule

bind field_accumulate_and_average faa_port_checker u_faa_checker (.*);
